// ----- rtl/core/rtc3w_pkg.sv -----
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Shared types and constants for the three-wire rtc register target:
// command byte fields, storage depths and response status codes.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

   // default sizes of the two burst windows
   localparam int RamBytesDefault      = 31;
   localparam int ClockBurstLenDefault = 8;

   // clock register file
   localparam int          ClockDepth = 9;
   localparam int          ClockAw    = 4;
   localparam logic [4:0]  WpReg      = 5'd7;

   // command byte layout
   localparam int          CmdValidBit = 7;
   localparam int          CmdRamBit   = 6;
   localparam int          CmdReadBit  = 0;
   localparam logic [4:0]  BurstAddr   = 5'd31;

   // response status codes
   typedef enum logic [2:0] {
      STATUS_CMD     = 3'd0,
      STATUS_WRITTEN = 3'd1,
      STATUS_READ    = 3'd2,
      STATUS_BLOCKED = 3'd3,
      STATUS_IGNORED = 3'd4,
      STATUS_ENDED   = 3'd5
   } status_type;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      STATE_IDLE = 3'b001,
      STATE_WAIT = 3'b010,
      STATE_RESP = 3'b100
   } state_type;

endpackage

// ----- rtl/core/rtc_three_wire_register_target_top.sv -----
// ----------------------------------------------------------------------------
// rtc_three_wire_register_target_top
// Byte-level device side of a three-wire rtc register interface: decodes
// command bytes, then writes or reads clock registers and user ram, with
// burst addressing and write protection.
// ----------------------------------------------------------------------------
//
//   channel   direction   fields                         handshake
//   req       in          req_func, req_data_byte        req_valid / req_ready
//   rsp       out         rsp_read_data, rsp_status      rsp_valid / rsp_ready
//
// The response is valid the cycle after its request beat is taken; a read slot
// first passes through the wait state, for the registered read port of the
// clock or ram memory. A new beat is taken only once the last response has
// left; one beat is in flight at a time and memory accesses never overlap.
// Reset clears the command state, the write-protect copy and the per-entry
// valid bits, so unwritten entries read as zero; no clearing pass is needed.
// A stalled response holds in the output register and keeps req_ready low.
//
module rtc_three_wire_register_target_top #(
   parameter int RAM_BYTES       = rtc3w_pkg::RamBytesDefault,
   parameter int CLOCK_BURST_LEN = rtc3w_pkg::ClockBurstLenDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_status
);

   localparam int         RamAw      = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
   localparam logic [4:0] RamLimit   = 5'(RAM_BYTES);
   localparam logic [4:0] BurstLimit = 5'(CLOCK_BURST_LEN);
   localparam logic [4:0] ClkLimit   = 5'(rtc3w_pkg::ClockDepth);

   // storage
   logic [7:0] clk_mem [rtc3w_pkg::ClockDepth];
   logic [7:0] ram_mem [RAM_BYTES];
   logic [rtc3w_pkg::ClockDepth-1:0] clk_vld_ff;
   logic [RAM_BYTES-1:0]             ram_vld_ff;

   // read port registers
   logic [7:0] clk_q_ff, ram_q_ff;
   logic       clk_qv_ff, ram_qv_ff;

   // control registers
   rtc3w_pkg::state_type state_ff, state_in;
   logic       have_cmd_ff, have_cmd_in;
   logic       cmd_read_ff, cmd_read_in;
   logic       cmd_ram_ff, cmd_ram_in;
   logic       cmd_burst_ff, cmd_burst_in;
   logic [4:0] addr_ff, addr_in;
   logic [4:0] done_ff, done_in;
   logic       wp_ff, wp_in;
   logic       hit_ff, hit_in;

   // response registers
   logic [7:0]             rsp_data_ff, rsp_data_in;
   rtc3w_pkg::status_type  rsp_status_ff, rsp_status_in;

   // decode helpers
   logic                        accept;
   logic                        loc_ok;
   logic [4:0]                  limit;
   logic                        slot_open;
   logic                        wp_block;
   logic                        rd_en;
   logic                        we;
   logic [4:0]                  cmd_addr;
   logic [rtc3w_pkg::ClockAw-1:0] clk_idx;
   logic [RamAw-1:0]            ram_idx;

   assign req_ready     = (state_ff == rtc3w_pkg::STATE_IDLE);
   assign rsp_valid     = (state_ff == rtc3w_pkg::STATE_RESP);
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign accept        = req_valid && req_ready;

   // location and window checks for the current data slot
   assign clk_idx   = addr_ff[rtc3w_pkg::ClockAw-1:0];
   assign ram_idx   = addr_ff[RamAw-1:0];
   assign loc_ok    = cmd_ram_ff ? (addr_ff < RamLimit) : (addr_ff < ClkLimit);
   assign limit     = cmd_burst_ff ? (cmd_ram_ff ? RamLimit : BurstLimit) : 5'd1;
   assign slot_open = (done_ff < limit);
   assign wp_block  = wp_ff && (cmd_ram_ff || (addr_ff != rtc3w_pkg::WpReg));
   assign cmd_addr  = req_data_byte[5:1];

   // beat sequencer
   always_comb begin
      state_in      = state_ff;
      have_cmd_in   = have_cmd_ff;
      cmd_read_in   = cmd_read_ff;
      cmd_ram_in    = cmd_ram_ff;
      cmd_burst_in  = cmd_burst_ff;
      addr_in       = addr_ff;
      done_in       = done_ff;
      wp_in         = wp_ff;
      hit_in        = hit_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      we            = 1'b0;
      case (state_ff)
         rtc3w_pkg::STATE_IDLE: begin
            if (accept) begin
               state_in    = rtc3w_pkg::STATE_RESP;
               rsp_data_in = 8'd0;
               if (req_func) begin
                  // chip enable dropped
                  have_cmd_in   = 1'b0;
                  cmd_read_in   = 1'b0;
                  cmd_ram_in    = 1'b0;
                  cmd_burst_in  = 1'b0;
                  addr_in       = 5'd0;
                  done_in       = 5'd0;
                  rsp_status_in = rtc3w_pkg::STATUS_ENDED;
               end else if (!have_cmd_ff) begin
                  if (req_data_byte[rtc3w_pkg::CmdValidBit]) begin
                     have_cmd_in   = 1'b1;
                     cmd_read_in   = req_data_byte[rtc3w_pkg::CmdReadBit];
                     cmd_ram_in    = req_data_byte[rtc3w_pkg::CmdRamBit];
                     cmd_burst_in  = (cmd_addr == rtc3w_pkg::BurstAddr);
                     addr_in       = (cmd_addr == rtc3w_pkg::BurstAddr) ? 5'd0 : cmd_addr;
                     done_in       = 5'd0;
                     rsp_status_in = rtc3w_pkg::STATUS_CMD;
                  end else begin
                     rsp_status_in = rtc3w_pkg::STATUS_IGNORED;
                  end
               end else if (!slot_open) begin
                  rsp_status_in = rtc3w_pkg::STATUS_IGNORED;
               end else begin
                  // data slot inside the window
                  done_in = done_ff + 5'd1;
                  if (cmd_burst_ff) begin
                     addr_in = addr_ff + 5'd1;
                  end
                  if (cmd_read_ff) begin
                     rd_en         = 1'b1;
                     hit_in        = loc_ok;
                     state_in      = rtc3w_pkg::STATE_WAIT;
                     rsp_status_in = rtc3w_pkg::STATUS_READ;
                  end else if (!loc_ok) begin
                     rsp_status_in = rtc3w_pkg::STATUS_IGNORED;
                  end else if (wp_block) begin
                     rsp_status_in = rtc3w_pkg::STATUS_BLOCKED;
                  end else begin
                     we            = 1'b1;
                     rsp_status_in = rtc3w_pkg::STATUS_WRITTEN;
                     if (!cmd_ram_ff && (addr_ff == rtc3w_pkg::WpReg)) begin
                        wp_in = req_data_byte[7];
                     end
                  end
               end
            end
         end
         rtc3w_pkg::STATE_WAIT: begin
            // read data from the memory port, unwritten entries as zero
            if (!hit_ff) begin
               rsp_data_in = 8'd0;
            end else if (cmd_ram_ff) begin
               rsp_data_in = ram_qv_ff ? ram_q_ff : 8'd0;
            end else begin
               rsp_data_in = clk_qv_ff ? clk_q_ff : 8'd0;
            end
            state_in = rtc3w_pkg::STATE_RESP;
         end
         rtc3w_pkg::STATE_RESP: begin
            if (rsp_ready) begin
               state_in = rtc3w_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = rtc3w_pkg::STATE_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtc3w_pkg::STATE_IDLE;
         have_cmd_ff  <= 1'b0;
         cmd_read_ff  <= 1'b0;
         cmd_ram_ff   <= 1'b0;
         cmd_burst_ff <= 1'b0;
         addr_ff      <= 5'd0;
         done_ff      <= 5'd0;
         wp_ff        <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_cmd_ff  <= have_cmd_in;
         cmd_read_ff  <= cmd_read_in;
         cmd_ram_ff   <= cmd_ram_in;
         cmd_burst_ff <= cmd_burst_in;
         addr_ff      <= addr_in;
         done_ff      <= done_in;
         wp_ff        <= wp_in;
         hit_ff       <= hit_in;
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_vld_ff <= '0;
         ram_vld_ff <= '0;
      end else if (we) begin
         if (cmd_ram_ff) begin
            ram_vld_ff[ram_idx] <= 1'b1;
         end else begin
            clk_vld_ff[clk_idx] <= 1'b1;
         end
      end
   end

   // clock register memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we && !cmd_ram_ff) begin
         clk_mem[clk_idx] <= req_data_byte;
      end
      if (rd_en && !cmd_ram_ff && loc_ok) begin
         clk_q_ff  <= clk_mem[clk_idx];
         clk_qv_ff <= clk_vld_ff[clk_idx];
      end
   end

   // user ram memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we && cmd_ram_ff) begin
         ram_mem[ram_idx] <= req_data_byte;
      end
      if (rd_en && cmd_ram_ff && loc_ok) begin
         ram_q_ff  <= ram_mem[ram_idx];
         ram_qv_ff <= ram_vld_ff[ram_idx];
      end
   end

endmodule
